// ===== sv/tick_quantum_scheduler_unit_assert.svh =====
// Assertion macros for the tick quantum scheduler unit.
// Needs a clock named clk and an active-high reset named rst at the point of use.
`ifndef TICK_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH
`define TICK_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define TQS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tick quantum scheduler check failed");

// Checked on every clock edge, reset included.
`define TQS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tick quantum scheduler check failed");

`else

`define TQS_ASSERT(lbl, prop)
`define TQS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== sv/tqs_pkg.sv =====
// Shared types and constants of the tick quantum scheduler unit.
// Used by tick_quantum_scheduler_unit and the testbench; depends on nothing.
package tqs_pkg;

  localparam int NUM_PROCS_DEF   = 16;
  localparam int SLICE_WIDTH_DEF = 16;

  localparam int PROC_FIELD_W  = 4;
  localparam int VALUE_FIELD_W = 16;
  localparam int TICK_W        = 32;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [PROC_FIELD_W-1:0]  proc_index;
    logic                     running;
    logic [VALUE_FIELD_W-1:0] priority_req;
    logic [VALUE_FIELD_W-1:0] slice_left;
  } req_t;

  typedef struct packed {
    logic [PROC_FIELD_W-1:0]  current_proc;
    logic                     switched;
    logic [VALUE_FIELD_W-1:0] current_left;
    logic [TICK_W-1:0]        tick_count;
  } res_t;

endpackage

// ===== sv/tick_quantum_scheduler_unit.sv =====
// Tick quantum scheduler: process table in two synchronous memories plus a scan sequencer.
// Depends on tqs_pkg and tick_quantum_scheduler_unit_assert.svh.
//
// A write request, or a tick that does not switch, gives its result once the current entry
// has been read and evaluated; a tick that reschedules also scans the table once or twice,
// one entry per cycle through the memory read port, before its result is given.
// Throughput: one request at a time; busy drops in the cycle the result strobe is shown,
// so the next request can be taken then. The receiver cannot stall the result.
// Reset: control state clears synchronously; table entries read as zero until written
// through per-entry valid flags, so there is no clearing pass.
`include "tick_quantum_scheduler_unit_assert.svh"

module tick_quantum_scheduler_unit
  import tqs_pkg::*;
#(
  parameter int NUM_PROCS   = NUM_PROCS_DEF,
  parameter int SLICE_WIDTH = SLICE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t result
);

  localparam int IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROCS - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,  // waiting for a request
    S_RD_CUR = 6'b000010,  // reading the current process entry
    S_EVAL   = 6'b000100,  // report a write, or decrement and decide whether to reschedule
    S_SCAN   = 6'b001000,  // pipelined scan over entries 1..NUM_PROCS-1
    S_ID_RD  = 6'b010000,  // reading the idle process entry
    S_ID_WR  = 6'b100000   // refilling the idle process
  } state_t;

  // The process table. Slice and priority share one read address, so each
  // read cycle returns both values of one entry.
  logic [SLICE_WIDTH-1:0] slice_mem [NUM_PROCS];
  logic [SLICE_WIDTH-1:0] prio_mem  [NUM_PROCS];

  // Control registers.
  state_t                 state, state_next;
  logic [IDX_W-1:0]       cur, cur_next;
  logic [TICK_W-1:0]      tick_cnt, tick_next;
  logic [NUM_PROCS-1:0]   vld, vld_next;   // entry written since reset
  logic [NUM_PROCS-1:0]   run, run_next;   // runnable flags
  logic                   pass_two, pass_next;
  logic                   iss_on, iss_next;
  logic                   cmp_vld, cmp_vld_next;
  logic                   done_next;

  // Datapath registers.
  logic [IDX_W-1:0]       scan_idx, scan_next;
  logic [IDX_W-1:0]       cmp_idx, cmp_idx_next;
  logic [IDX_W-1:0]       best, best_next;
  logic [SLICE_WIDTH-1:0] best_ticks, bt_next;
  logic                   kind_q, kind_next;
  res_t                   res_next;
  logic [SLICE_WIDTH-1:0] slice_q, prio_q;
  logic                   rd_vld;

  // Memory port controls.
  logic [IDX_W-1:0]       rd_addr;
  logic                   sw_we;
  logic [IDX_W-1:0]       sw_addr;
  logic [SLICE_WIDTH-1:0] sw_data;
  logic                   pw_we;

  // Helpers.
  logic [IDX_W-1:0]       wr_idx;
  logic                   idx_ok;
  logic [SLICE_WIDTH-1:0] slice_rd, prio_rd, dec, scan_val;

  // A write names an entry; indexes past the table are dropped.
  assign wr_idx = IDX_W'(req.proc_index);
  assign idx_ok = ({28'd0, req.proc_index} < 32'(NUM_PROCS));

  // Entries never written read as zero.
  assign slice_rd = rd_vld ? slice_q : '0;
  assign prio_rd  = rd_vld ? prio_q  : '0;

  // The current process loses one tick, stopping at zero.
  assign dec = (slice_rd != '0) ? slice_rd - SLICE_WIDTH'(1) : '0;

  // The first pass ranks remaining ticks; the second pass ranks the refill
  // values, which are exactly the slices after a refill of the running entries.
  assign scan_val = pass_two ? prio_rd : slice_rd;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    tick_next    = tick_cnt;
    vld_next     = vld;
    run_next     = run;
    pass_next    = pass_two;
    iss_next     = iss_on;
    scan_next    = scan_idx;
    cmp_vld_next = 1'b0;
    cmp_idx_next = scan_idx;
    best_next    = best;
    bt_next      = best_ticks;
    kind_next    = kind_q;
    done_next    = 1'b0;
    res_next     = result;
    rd_addr      = cur;
    sw_we        = 1'b0;
    sw_addr      = cur;
    sw_data      = dec;
    pw_we        = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          kind_next  = req.kind;
          state_next = S_RD_CUR;
          if (req.kind == KIND_TICK) begin
            tick_next = tick_cnt + TICK_W'(1);
          end else if (idx_ok) begin
            sw_we            = 1'b1;
            sw_addr          = wr_idx;
            sw_data          = SLICE_WIDTH'(req.slice_left);
            pw_we            = 1'b1;
            vld_next[wr_idx] = 1'b1;
            run_next[wr_idx] = req.running;
          end
        end
      end

      S_RD_CUR: begin
        rd_addr    = cur;
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (kind_q == KIND_WRITE) begin
          res_next.current_proc = PROC_FIELD_W'(cur);
          res_next.switched     = 1'b0;
          res_next.current_left = VALUE_FIELD_W'(slice_rd);
          res_next.tick_count   = tick_cnt;
          done_next             = 1'b1;
          state_next            = S_IDLE;
        end else begin
          // An entry never written holds zero and needs no write back.
          sw_we   = rd_vld;
          sw_addr = cur;
          sw_data = dec;
          if (dec != '0) begin
            res_next.current_proc = PROC_FIELD_W'(cur);
            res_next.switched     = 1'b0;
            res_next.current_left = VALUE_FIELD_W'(dec);
            res_next.tick_count   = tick_cnt;
            done_next             = 1'b1;
            state_next            = S_IDLE;
          end else begin
            pass_next  = 1'b0;
            scan_next  = FIRST_IDX;
            iss_next   = 1'b1;
            best_next  = '0;
            bt_next    = '0;
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; compare the entry read in the previous cycle.
        rd_addr = scan_idx;
        if (iss_on) begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = scan_idx;
          if (scan_idx == LAST_IDX) begin
            iss_next = 1'b0;
          end else begin
            scan_next = scan_idx + FIRST_IDX;
          end
        end
        if (cmp_vld) begin
          // Strict compare keeps the lowest index on a tie.
          if (run[cmp_idx] && (scan_val > best_ticks)) begin
            best_next = cmp_idx;
            bt_next   = scan_val;
          end
          if (pass_two && run[cmp_idx]) begin
            sw_we   = 1'b1;
            sw_addr = cmp_idx;
            sw_data = prio_rd;
          end
          if (cmp_idx == LAST_IDX) begin
            if (best_next != '0) begin
              cur_next              = best_next;
              res_next.current_proc = PROC_FIELD_W'(best_next);
              res_next.switched     = 1'b1;
              res_next.current_left = VALUE_FIELD_W'(bt_next);
              res_next.tick_count   = tick_cnt;
              done_next             = 1'b1;
              state_next            = S_IDLE;
            end else if (!pass_two) begin
              pass_next = 1'b1;
              scan_next = FIRST_IDX;
              iss_next  = 1'b1;
              best_next = '0;
              bt_next   = '0;
            end else begin
              state_next = S_ID_RD;
            end
          end
        end
      end

      S_ID_RD: begin
        rd_addr    = '0;
        state_next = S_ID_WR;
      end

      S_ID_WR: begin
        sw_we                 = rd_vld;
        sw_addr               = '0;
        sw_data               = prio_rd;
        cur_next              = '0;
        res_next.current_proc = '0;
        res_next.switched     = 1'b1;
        res_next.current_left = VALUE_FIELD_W'(prio_rd);
        res_next.tick_count   = tick_cnt;
        done_next             = 1'b1;
        state_next            = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur      <= '0;
      tick_cnt <= '0;
      vld      <= '0;
      run      <= '0;
      pass_two <= 1'b0;
      iss_on   <= 1'b0;
      cmp_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      tick_cnt <= tick_next;
      vld      <= vld_next;
      run      <= run_next;
      pass_two <= pass_next;
      iss_on   <= iss_next;
      cmp_vld  <= cmp_vld_next;
      done     <= done_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    scan_idx   <= scan_next;
    cmp_idx    <= cmp_idx_next;
    best       <= best_next;
    best_ticks <= bt_next;
    kind_q     <= kind_next;
    result     <= res_next;
    rd_vld     <= vld[rd_addr];
  end

  // Table memories: one write port each, one shared read address with registered read data.
  always_ff @(posedge clk) begin
    if (sw_we) begin
      slice_mem[sw_addr] <= sw_data;
    end
    if (pw_we) begin
      prio_mem[wr_idx] <= SLICE_WIDTH'(req.priority_req);
    end
    slice_q <= slice_mem[rd_addr];
    prio_q  <= prio_mem[rd_addr];
  end

  // An accepted request always makes the unit busy in the next cycle.
  `TQS_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  // A result strobe coincides with the return to idle.
  `TQS_ASSERT(a_done_idle, done |-> !busy)
  // One request yields one strobe, never two in a row.
  `TQS_ASSERT(a_done_single, done |=> !done)
  // Scan compares only run inside the scan state.
  `TQS_ASSERT(a_cmp_in_scan, cmp_vld |-> (state == S_SCAN))
  // Out of reset the unit is idle with no pending strobe.
  `TQS_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for tick_quantum_scheduler_unit: directed requests, then random
// phases of table writes and ticks, each result checked against an in-bench scheduler model.
// Depends on tqs_pkg and the RTL of tick_quantum_scheduler_unit.
module testbench;
  import tqs_pkg::*;

  localparam int PROCS        = NUM_PROCS_DEF;
  localparam int RANDOM_ITEMS = 1850;
  // The slowest correct run is about 1900 requests, each with its idle gap, a full
  // reschedule and the handshake, which stays well below this limit.
  localparam int LIMIT_CYCLES = 400000;
  // At the end, wait longer than the slowest rescheduling tick takes.
  localparam int TAIL_CYCLES  = 2 * PROCS + 10;
  localparam int SHOWN_ERRORS = 10;

  // One pending request: its payload, the idle cycles before it is offered, and whether
  // the driver must first wait until every outstanding result has come back.
  typedef struct {
    req_t        payload;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  res_t result;

  pending_t pending_reqs[$];
  res_t     awaited_status[$];

  int unsigned gap_cap        = 0;
  int unsigned idle_cycles    = 0;
  int unsigned sent_count     = 0;
  int unsigned received_count = 0;
  int unsigned mismatch_count = 0;

  // Scheduler state as the block should hold it.
  logic [VALUE_FIELD_W-1:0] slice_mirror  [PROCS];
  logic [VALUE_FIELD_W-1:0] refill_mirror [PROCS];
  bit                       runnable_mirror [PROCS];
  logic [PROC_FIELD_W-1:0]  cur_proc_mirror = '0;
  logic [TICK_W-1:0]        tick_mirror     = '0;

  tick_quantum_scheduler_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Index of the runnable process 1..PROCS-1 with the most ticks left; the lowest index
  // wins a tie. Zero means no runnable process has any ticks.
  function automatic int busiest_proc();
    int best;
    logic [VALUE_FIELD_W-1:0] best_ticks;
    best = 0;
    best_ticks = '0;
    for (int i = 1; i < PROCS; i++) begin
      if (runnable_mirror[i] && slice_mirror[i] > best_ticks) begin
        best_ticks = slice_mirror[i];
        best = i;
      end
    end
    return best;
  endfunction

  // Applies one accepted request to the mirrored state and returns the status it reports.
  function automatic res_t next_schedule(input req_t r);
    res_t status;
    int pick;
    bit any_runnable;
    status = '0;
    if (r.kind == KIND_WRITE) begin
      // Indexes past the table are dropped; at 16 entries every index is in range.
      if (int'(r.proc_index) < PROCS) begin
        runnable_mirror[r.proc_index] = r.running;
        refill_mirror[r.proc_index]   = r.priority_req;
        slice_mirror[r.proc_index]    = r.slice_left;
      end
    end else begin
      tick_mirror = tick_mirror + 1'b1;
      // The current process loses a tick even if it is no longer runnable.
      if (slice_mirror[cur_proc_mirror] != '0)
        slice_mirror[cur_proc_mirror] = slice_mirror[cur_proc_mirror] - 1'b1;
      if (slice_mirror[cur_proc_mirror] == '0) begin
        status.switched = 1'b1;
        pick = busiest_proc();
        if (pick == 0) begin
          // Everyone runnable is exhausted: refill them all and look once more.
          any_runnable = 1'b0;
          for (int i = 1; i < PROCS; i++) begin
            if (runnable_mirror[i]) begin
              slice_mirror[i] = refill_mirror[i];
              any_runnable = 1'b1;
            end
          end
          if (any_runnable)
            pick = busiest_proc();
        end
        if (pick != 0) begin
          cur_proc_mirror = PROC_FIELD_W'(pick);
        end else begin
          // Nothing to run: fall back to the idle process with a fresh slice.
          slice_mirror[0] = refill_mirror[0];
          cur_proc_mirror = '0;
        end
      end
    end
    status.current_proc = cur_proc_mirror;
    status.current_left = slice_mirror[cur_proc_mirror];
    status.tick_count   = tick_mirror;
    return status;
  endfunction

  // Mostly short slices so that ticks reach zero often, plus zero, the maximum and
  // values of random width so that every bit gets exercised.
  function automatic logic [VALUE_FIELD_W-1:0] tick_amount();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 62)
      return VALUE_FIELD_W'($urandom_range(1, 5));
    else if (roll < 76)
      return '0;
    else if (roll < 86)
      return VALUE_FIELD_W'(1);
    else if (roll < 88)
      return '1;
    else
      return VALUE_FIELD_W'($urandom & ((32'd1 << $urandom_range(1, VALUE_FIELD_W)) - 1));
  endfunction

  task automatic queue_request(input req_t r, input bit drain);
    pending_t p;
    p.payload = r;
    p.gap     = $urandom_range(0, gap_cap);
    p.drain   = drain;
    pending_reqs.push_back(p);
  endtask

  task automatic queue_write(input int idx, input bit run, input logic [15:0] refill,
                             input logic [15:0] ticks, input bit drain = 1'b0);
    req_t r;
    r = '0;
    r.kind         = KIND_WRITE;
    r.proc_index   = PROC_FIELD_W'(idx);
    r.running      = run;
    r.priority_req = refill;
    r.slice_left   = ticks;
    queue_request(r, drain);
  endtask

  task automatic queue_tick(input bit drain = 1'b0);
    req_t r;
    logic [63:0] noise;
    // The table fields of a tick are ignored by the block, so they carry noise.
    noise = {$urandom, $urandom};
    r = req_t'(noise[$bits(req_t)-1:0]);
    r.kind = KIND_TICK;
    queue_request(r, drain);
  endtask

  task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
        $display("result %0d: %s expected %0h, got %0h", received_count, name, want, got);
    end
  endtask

  // Driver: offers the next pending request once its gap has passed and, for a draining
  // request, once every result so far has been received. start stays high through the
  // acceptance edge when the following request has no gap, with a single assignment.
  always @(posedge clk) begin : drive_requests
    pending_t nxt;
    if (rst) begin
      start <= 1'b0;
      idle_cycles = 0;
    end else if (start && busy) begin
      // The offered request is still waiting; hold it.
    end else begin
      if (start) begin
        // Accepted at this edge: the model advances in acceptance order.
        awaited_status.push_back(next_schedule(req));
        sent_count++;
        idle_cycles = 0;
      end
      if (pending_reqs.size() != 0 && idle_cycles >= pending_reqs[0].gap &&
          (!pending_reqs[0].drain || sent_count == received_count)) begin
        nxt = pending_reqs.pop_front();
        req   <= nxt.payload;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        idle_cycles++;
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && done) begin
      received_count <= received_count + 1;
      if (awaited_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
          $display("result %0d arrived with nothing outstanding: %h", received_count, result);
      end else begin
        want = awaited_status.pop_front();
        check_field("current_proc", TICK_W'(want.current_proc), TICK_W'(result.current_proc));
        check_field("switched", TICK_W'(want.switched), TICK_W'(result.switched));
        check_field("current_left", TICK_W'(want.current_left), TICK_W'(result.current_left));
        check_field("tick_count", want.tick_count, result.tick_count);
      end
    end
  end

  initial begin : run_test
    int unsigned made;
    int unsigned span;
    int unsigned mode;
    int unsigned waited;
    bit timed_out;
    bit run;
    logic [VALUE_FIELD_W-1:0] refill;

    for (int i = 0; i < PROCS; i++) begin
      slice_mirror[i]    = '0;
      refill_mirror[i]   = '0;
      runnable_mirror[i] = 1'b0;
    end

    // Directed part. A tick straight after reset finds nothing runnable and an idle
    // process with zero priority, so it picks idle with zero ticks.
    gap_cap = 12;
    queue_tick();
    queue_tick();
    queue_write(0, 1'b0, 16'd3, 16'd2);
    queue_tick();
    // Extreme values on the highest index; it wins the next pick outright.
    queue_write(15, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_write(1, 1'b1, 16'd2, 16'd0);
    queue_tick();
    // The current process stops being runnable but keeps its slice until it runs out.
    queue_write(15, 1'b0, 16'd0, 16'd1);
    queue_tick();
    // Two processes tie on remaining ticks; the lower index must win.
    queue_write(2, 1'b1, 16'd5, 16'd2);
    queue_write(3, 1'b1, 16'd5, 16'd2);
    queue_tick();
    queue_tick();
    // Process 1 stays runnable with zero priority and process 3 stops: when process 2
    // runs out, the refill leaves only process 2 with ticks, so it is picked again.
    queue_write(1, 1'b1, 16'd0, 16'd0);
    queue_write(3, 1'b0, 16'd0, 16'd0);
    queue_tick(1'b1);
    queue_tick();
    queue_write(2, 1'b0, 16'h8000, 16'h7FFF);
    queue_tick();
    queue_tick();
    queue_tick();
    // Writing the slice of the idle process while process 2 is current does not change what the next tick sees.
    queue_write(0, 1'b1, 16'h5555, 16'd1);
    queue_write(7, 1'b1, 16'hAAAA, 16'd0);
    queue_tick();
    queue_tick();
    queue_write(7, 1'b0, 16'h0000, 16'h0000);

    // Random part in phases, each with its own idling style and mix of requests.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       gap_cap = 0;
        1:       gap_cap = 3;
        default: gap_cap = 12;
      endcase
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 80);
      for (int k = 0; k < span && made < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < (mode == 1 ? 85 : 55)) begin
          queue_tick((made == 0) || (k == 0 && $urandom_range(0, 3) == 0));
        end else begin
          // Phase 2 mostly stops processes from running, phase 3 mostly gives them zero priority.
          run = ($urandom_range(0, 99) < (mode == 2 ? 15 : 80));
          refill = (mode == 3 && $urandom_range(0, 99) < 85) ? '0 : tick_amount();
          queue_write($urandom_range(0, PROCS - 1), run, refill, tick_amount(),
                      (made == 0) || (k == 0 && $urandom_range(0, 3) == 0));
        end
        made++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    waited = 0;
    timed_out = 1'b0;
    while (pending_reqs.size() != 0 || start || sent_count != received_count) begin
      @(negedge clk);
      waited++;
      if (waited > LIMIT_CYCLES) begin
        timed_out = 1'b1;
        break;
      end
    end

    if (timed_out) begin
      $display("CHECK FAILED");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (mismatch_count == 0 && awaited_status.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule
